// ----- rtl/scb_pkg.sv -----
package scb_pkg;

  localparam int LatBandsDefault = 32;
  localparam int LonBandsDefault = 36;
  localparam int CordicSteps     = 28;
  localparam int StepW           = 5;
  localparam int AngW            = 36;
  localparam int VecW            = 48;
  localparam logic [14:0] LimitReset = 15'd4506;

  typedef struct packed {
    logic signed [15:0] mag_cal_x;
    logic signed [15:0] mag_cal_y;
    logic signed [15:0] mag_cal_z;
    logic signed [15:0] accel_cal_x;
    logic signed [15:0] accel_cal_y;
    logic signed [15:0] accel_cal_z;
    logic signed [15:0] mag_raw_x;
    logic signed [15:0] mag_raw_y;
    logic signed [15:0] mag_raw_z;
    logic signed [15:0] accel_raw_x;
    logic signed [15:0] accel_raw_y;
    logic signed [15:0] accel_raw_z;
  } in_beat_t;

  typedef struct packed {
    logic [10:0] accel_cell;
    logic        accel_stored;
    logic [10:0] mag_cell;
    logic        mag_stored;
    logic [10:0] accel_filled;
    logic [10:0] mag_filled;
  } out_beat_t;

  // Datapath commands from the controller.
  typedef struct packed {
    logic       load;      // capture input beat
    logic       sel_accel; // operate on accel vector
    logic       sq_start;  // start sum of squares / setup
    logic       sqrt_step; // one root digit
    logic       lon_init;  // start longitude rotation
    logic       lat_init;  // start latitude rotation
    logic       rot_step;  // one rotation step
    logic       lon_done;  // register longitude band
    logic       lat_done;  // register latitude band, form cell
    logic       commit;    // check occupancy and update
    logic       clear_en;  // clearing sweep write
  } scb_cmd_t;

  typedef struct packed {
    logic last_step;
    logic last_root;
    logic clear_last;
  } scb_sts_t;

  function automatic logic [31:0] atan_entry(input logic [StepW-1:0] i);
    logic [31:0] t;
    unique case (i)
      5'd0: t = 32'h20000000;  5'd1: t = 32'h12E4051E;  5'd2: t = 32'h09FB385B;
      5'd3: t = 32'h051111D4;  5'd4: t = 32'h028B0D43;  5'd5: t = 32'h0145D7E1;
      5'd6: t = 32'h00A2F61E;  5'd7: t = 32'h00517C55;  5'd8: t = 32'h0028BE53;
      5'd9: t = 32'h00145F2F;  5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
      5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3; 5'd14: t = 32'h0000A2FA;
      5'd15: t = 32'h0000517D; 5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
      5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518; 5'd20: t = 32'h0000028C;
      5'd21: t = 32'h00000146; 5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
      5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014; 5'd26: t = 32'h0000000A;
      5'd27: t = 32'h00000005;
      default: t = 32'h0;
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/scb_if.sv -----
interface scb_in_if;
  import scb_pkg::*;
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface scb_out_if;
  import scb_pkg::*;
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/scb_datapath.sv -----
module scb_datapath import scb_pkg::*; #(
  parameter int LAT_BANDS = LatBandsDefault,
  parameter int LON_BANDS = LonBandsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  scb_cmd_t    cmd_i,
  output scb_sts_t    sts_o,
  input  in_beat_t    beat_i,
  input  logic [14:0] limit_i,
  output out_beat_t   res_o
);

  localparam int Cells = LAT_BANDS * LON_BANDS;
  localparam int CellW = $clog2(Cells);
  localparam int LatW  = $clog2(LAT_BANDS);
  localparam int LonW  = $clog2(LON_BANDS);

  // Captured beat.
  in_beat_t beat_q;
  // Working vector and derived values.
  logic signed [15:0] vx, vy, vz;
  logic [33:0] sq_q, sq_d;      // sum of three squares
  logic [31:0] sxy_q;           // x^2 + y^2
  logic [1:0]  sq_ph_q;
  logic [48:0] rem_q;           // root remainder
  logic [24:0] root_q;          // root of sxy<<16
  logic [4:0]  rcnt_q;
  logic signed [VecW-1:0] x_q, y_q;
  logic signed [AngW-1:0] a_q;
  logic [StepW-1:0] step_q;
  logic [LonW-1:0] lon_q;
  logic [CellW-1:0] cell_q;
  logic [10:0] acount_q, mcount_q;
  // Accel part of the beat in progress, held until the magnetometer part is done.
  logic [10:0] acell_q;
  logic        astored_q;
  out_beat_t res_q;

  // Occupancy and sample stores.
  logic occ_a [Cells];
  logic occ_m [Cells];
  logic [47:0] smp_a [Cells];
  logic [47:0] smp_m [Cells];
  logic occ_a_rd_q, occ_m_rd_q;
  logic [CellW-1:0] clr_q;

  assign vx = cmd_i.sel_accel ? beat_q.accel_cal_x : beat_q.mag_cal_x;
  assign vy = cmd_i.sel_accel ? beat_q.accel_cal_y : beat_q.mag_cal_y;
  assign vz = cmd_i.sel_accel ? beat_q.accel_cal_z : beat_q.mag_cal_z;

  // One squarer: x, y and z in turn.
  logic signed [15:0] sq_op;
  logic signed [31:0] sq_w;
  logic [31:0] sq_p;
  always_comb begin
    unique case (sq_ph_q)
      2'd0:    sq_op = vx;
      2'd1:    sq_op = vy;
      default: sq_op = vz;
    endcase
    sq_w = 32'(sq_op);
    sq_p = 32'(sq_w * sq_w);
    sq_d = sq_q + 34'(sq_p);
  end

  // Root digit.
  logic [48:0] trial;
  logic [48:0] rem_sh;
  logic [49:0] sv;
  always_comb begin
    sv     = {2'b0, sxy_q, 16'h0};
    rem_sh = {rem_q[46:0], sv[6'(2*rcnt_q)+:2]};
    trial  = {22'h0, root_q, 2'b01};
  end

  // Rotation step.
  logic signed [VecW-1:0] dx, dy;
  assign dx = y_q >>> step_q;
  assign dy = x_q >>> step_q;

  // Band from angle: u clamped, times bands, top bits.
  logic signed [AngW+1:0] u_lon, u_lat;
  logic [31:0] ulc, uac;
  logic [38:0] plon, plat;
  logic [LonW-1:0] lon_b;
  logic [LatW-1:0] lat_b;
  always_comb begin
    u_lon = (AngW+2)'(a_q) + (AngW+2)'(64'sd2147483648);
    u_lat = ((AngW+2)'(a_q) + (AngW+2)'(64'sd1073741824)) <<< 1;
    ulc = u_lon < 0 ? 32'h0 : (u_lon > 38'sh0FFFFFFFF ? 32'hFFFFFFFF : u_lon[31:0]);
    uac = u_lat < 0 ? 32'h0 : (u_lat > 38'sh0FFFFFFFF ? 32'hFFFFFFFF : u_lat[31:0]);
    plon = 39'(({7'h0, ulc} * 39'(LON_BANDS)) >> 32);
    plat = 39'(({7'h0, uac} * 39'(LAT_BANDS)) >> 32);
    lon_b = plon >= 39'(LON_BANDS) ? LonW'(LON_BANDS-1) : LonW'(plon);
    lat_b = plat >= 39'(LAT_BANDS) ? LatW'(LAT_BANDS-1) : LatW'(plat);
  end

  // CORDIC initial vector with left-half fold.
  logic signed [VecW-1:0] ix, iy;
  always_comb begin
    if (cmd_i.lon_init) begin
      ix = VecW'(vx) <<< 16;
      iy = VecW'(vy) <<< 16;
    end else begin
      ix = VecW'({23'h0, root_q}) <<< 8;
      iy = VecW'(vz) <<< 16;
    end
  end

  logic [31:0] lim2;
  logic lim_ok;
  logic nz;
  logic store_a, store_m;
  logic [47:0] raw;
  assign lim2    = limit_i * limit_i;
  assign lim_ok  = !cmd_i.sel_accel || (sq_q <= 34'(lim2));
  assign nz      = sq_q != 34'h0;
  assign store_a = cmd_i.sel_accel && nz && lim_ok && !occ_a_rd_q;
  assign store_m = !cmd_i.sel_accel && nz && !occ_m_rd_q;
  assign raw = cmd_i.sel_accel
             ? {beat_q.accel_raw_z, beat_q.accel_raw_y, beat_q.accel_raw_x}
             : {beat_q.mag_raw_z, beat_q.mag_raw_y, beat_q.mag_raw_x};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) beat_q <= beat_i;
    if (cmd_i.sq_start) begin
      sq_q <= '0; sq_ph_q <= '0; rem_q <= '0; root_q <= '0; rcnt_q <= 5'd24;
    end else if (sq_ph_q != 2'd3 && !cmd_i.sqrt_step && !cmd_i.rot_step
                 && !cmd_i.lon_init && !cmd_i.lat_init) begin
      sq_q <= sq_d;
      if (sq_ph_q == 2'd1) sxy_q <= sq_d[31:0];
      sq_ph_q <= sq_ph_q + 2'd1;
    end
    if (cmd_i.sqrt_step) begin
      if (rem_sh >= trial) begin
        rem_q <= rem_sh - trial; root_q <= {root_q[23:0], 1'b1};
      end else begin
        rem_q <= rem_sh; root_q <= {root_q[23:0], 1'b0};
      end
      rcnt_q <= rcnt_q - 5'd1;
    end
    if (cmd_i.lon_init || cmd_i.lat_init) begin
      step_q <= '0;
      if (ix < 0) begin
        x_q <= -ix; y_q <= -iy;
        a_q <= iy >= 0 ? AngW'(64'sd2147483648) : -AngW'(64'sd2147483648);
      end else begin
        x_q <= ix; y_q <= iy; a_q <= '0;
      end
    end else if (cmd_i.rot_step) begin
      if (y_q < 0) begin
        x_q <= x_q - dx; y_q <= y_q + dy;
        a_q <= a_q - AngW'(atan_entry(step_q));
      end else begin
        x_q <= x_q + dx; y_q <= y_q - dy;
        a_q <= a_q + AngW'(atan_entry(step_q));
      end
      step_q <= step_q + 1'b1;
    end
    if (cmd_i.lon_done) lon_q <= lon_b;
    if (cmd_i.lat_done) cell_q <= CellW'(lat_b * LON_BANDS + lon_q);
  end

  // Counts and result; the result register is loaded once per beat, at the
  // magnetometer commit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acount_q <= '0; mcount_q <= '0; clr_q <= '0; res_q <= '0;
      acell_q <= '0; astored_q <= 1'b0;
    end else begin
      if (cmd_i.clear_en) clr_q <= clr_q + 1'b1;
      if (cmd_i.commit) begin
        if (cmd_i.sel_accel) begin
          acell_q   <= nz ? 11'(cell_q) : '0;
          astored_q <= store_a;
          if (store_a) acount_q <= acount_q + 11'd1;
        end else begin
          res_q.accel_cell   <= acell_q;
          res_q.accel_stored <= astored_q;
          res_q.accel_filled <= acount_q;
          res_q.mag_cell     <= nz ? 11'(cell_q) : '0;
          res_q.mag_stored   <= store_m;
          res_q.mag_filled   <= store_m ? mcount_q + 11'd1 : mcount_q;
          if (store_m) mcount_q <= mcount_q + 11'd1;
        end
      end
    end
  end

  // Occupancy and sample stores with a registered occupancy read at the current cell.
  always_ff @(posedge clk_i) begin
    occ_a_rd_q <= occ_a[cell_q];
    occ_m_rd_q <= occ_m[cell_q];
    if (cmd_i.clear_en) begin
      occ_a[clr_q] <= 1'b0; occ_m[clr_q] <= 1'b0;
    end else if (cmd_i.commit) begin
      if (store_a) begin
        occ_a[cell_q] <= 1'b1; smp_a[cell_q] <= raw;
      end
      if (store_m) begin
        occ_m[cell_q] <= 1'b1; smp_m[cell_q] <= raw;
      end
    end
  end

  assign sts_o.last_step  = step_q == StepW'(CordicSteps-1);
  assign sts_o.last_root  = rcnt_q == 5'd0;
  assign sts_o.clear_last = clr_q == CellW'(Cells-1);
  assign res_o = res_q;

endmodule

// ----- rtl/scb_ctrl.sv -----
module scb_ctrl import scb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  scb_sts_t sts_i,
  output scb_cmd_t cmd_o
);

  localparam logic [3:0] StClear = 4'd0, StIdle = 4'd1, StSq0 = 4'd2, StSq1 = 4'd3,
                         StSq2 = 4'd4, StRoot = 4'd5, StLon = 4'd6, StLonEnd = 4'd7,
                         StLat = 4'd8, StLatEnd = 4'd9, StCommit = 4'd10, StSetup = 4'd11,
                         StLatInit = 4'd12, StLookup = 4'd13;

  logic [3:0] st_q, st_d;
  logic acc_q, acc_d, ov_q, ov_d;

  always_comb begin
    st_d = st_q; acc_d = acc_q; ov_d = ov_q; cmd_o = '0;
    cmd_o.sel_accel = acc_q;
    in_ready_o = (st_q == StIdle);
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (st_q)
      StClear: begin
        cmd_o.clear_en = 1'b1;
        if (sts_i.clear_last) st_d = StIdle;
      end
      StIdle: if (in_valid_i && in_ready_o) begin
        cmd_o.load = 1'b1; acc_d = 1'b1; st_d = StSetup;
      end
      StSetup: begin cmd_o.sq_start = 1'b1; st_d = StSq0; end
      StSq0: st_d = StSq1;
      StSq1: st_d = StSq2;
      StSq2: begin cmd_o.lon_init = 1'b1; st_d = StLon; end
      StLon: begin
        cmd_o.rot_step = 1'b1;
        if (sts_i.last_step) st_d = StLonEnd;
      end
      StLonEnd: begin cmd_o.lon_done = 1'b1; st_d = StRoot; end
      StRoot: begin
        cmd_o.sqrt_step = 1'b1;
        if (sts_i.last_root) st_d = StLatInit;
      end
      // Latitude rotation starts from a fresh vector after the root.
      StLatInit: begin cmd_o.lat_init = 1'b1; st_d = StLat; end
      StLat: begin
        cmd_o.rot_step = 1'b1;
        if (sts_i.last_step) st_d = StLatEnd;
      end
      StLatEnd: begin cmd_o.lat_done = 1'b1; st_d = StLookup; end
      StLookup: st_d = StCommit;
      // The final commit waits while an earlier result is still held.
      StCommit: begin
        if (acc_q) begin
          cmd_o.commit = 1'b1; acc_d = 1'b0; st_d = StSetup;
        end else if (!ov_q || out_ready_i) begin
          cmd_o.commit = 1'b1; ov_d = 1'b1; st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; acc_q <= 1'b0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; acc_q <= acc_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;

endmodule

// ----- rtl/sphere_coverage_binner.sv -----
// Each accepted beat is handled for the accel vector, then the magnetometer: setup and
// squaring, 28 longitude steps of one shared CORDIC, 25 root digits, 28 latitude steps,
// and the bands, the cell, the occupancy lookup and the commit. The next beat is taken
// only once the last one is committed; a result left waiting holds the next beat at its
// final commit until it is taken. Reset: asynchronous, active low; a clearing sweep of one
// cycle per cell (1152 by default) empties the occupancy maps before the first beat.
module sphere_coverage_binner import scb_pkg::*; #(
  parameter int LAT_BANDS = LatBandsDefault,
  parameter int LON_BANDS = LonBandsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [14:0] cfg_wdata_i,
  scb_in_if.sink      in_if,
  scb_out_if.source   out_if
);

  scb_cmd_t cmd;
  scb_sts_t sts;
  logic [14:0] limit_q;

  // Magnitude limit register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= LimitReset;
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  scb_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_if.valid), .in_ready_o(in_if.ready),
    .out_valid_o(out_if.valid), .out_ready_i(out_if.ready),
    .sts_i(sts), .cmd_o(cmd)
  );

  scb_datapath #(.LAT_BANDS(LAT_BANDS), .LON_BANDS(LON_BANDS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .sts_o(sts), .beat_i(in_if.data),
    .limit_i(limit_q), .res_o(out_if.data)
  );

endmodule

// ----- verif/sphere_coverage_binner_test.sv -----
module sphere_coverage_binner_test;
  import scb_pkg::*;

  localparam int LonBands = LonBandsDefault;
  localparam int LatBands = LatBandsDefault;
  localparam int Cells    = LatBands * LonBands;
  localparam int CycleLimit = 3000000;

  localparam longint AtanTurn [28] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43, 64'h0145D7E1,
    64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D, 64'h000028BE, 64'h0000145F,
    64'h00000A30, 64'h00000518, 64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051,
    64'h00000029, 64'h00000014, 64'h0000000A, 64'h00000005
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [14:0] cfg_wdata_i = '0;

  scb_in_if  in_if ();
  scb_out_if out_if ();

  sphere_coverage_binner uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // Predictor state: occupancy maps, fill counts and the magnitude limit.
  bit          accel_occ [Cells];
  bit          mag_occ [Cells];
  logic [10:0] accel_fill_cnt;
  logic [10:0] mag_fill_cnt;
  logic [14:0] mag_limit = LimitReset;

  in_beat_t  pending_readings [$];
  out_beat_t expected_bins [$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        send_gap = 0;
  int        recv_gap = 0;
  bit        calm = 1'b0;
  bit        hold_off = 1'b0;
  bit        long_hold_req = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Vectoring rotation: binary angle of (x, y), 2^32 units per turn.
  function automatic longint rotate_angle(longint x, longint y);
    longint acc, dx, dy;
    acc = 0;
    if (x < 0) begin
      acc = (y >= 0) ? (longint'(1) <<< 31) : -(longint'(1) <<< 31);
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 28; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; acc -= AtanTurn[i];
      end else begin
        x += dx; y -= dy; acc += AtanTurn[i];
      end
    end
    return acc;
  endfunction

  function automatic longint floor_sqrt(bit [63:0] v);
    bit [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic int band_index(longint u, int n);
    bit [63:0] idx;
    if (u < 0) u = 0;
    if (u > 64'hFFFFFFFF) u = 64'hFFFFFFFF;
    idx = ($unsigned(u) * 64'(n)) >> 32;
    if (idx >= 64'(n)) idx = 64'(n - 1);
    return int'(idx);
  endfunction

  function automatic int direction_cell(int x, int y, int z);
    longint sxy, rad, lon_a, lat_a;
    sxy = longint'(x) * x + longint'(y) * y;
    lon_a = rotate_angle(longint'(x) * 65536, longint'(y) * 65536);
    rad = floor_sqrt(sxy <<< 16) <<< 8;
    lat_a = rotate_angle(rad, longint'(z) * 65536);
    return band_index(2 * (lat_a + (longint'(1) <<< 30)), LatBands) * LonBands +
           band_index(lon_a + (longint'(1) <<< 31), LonBands);
  endfunction

  // Bins one reading pair and updates the occupancy maps.
  function automatic out_beat_t bin_reading(in_beat_t b);
    out_beat_t r;
    longint a2, m2, lim2;
    int bin_idx;
    r = '0;
    a2 = longint'(b.accel_cal_x) * b.accel_cal_x + longint'(b.accel_cal_y) * b.accel_cal_y +
         longint'(b.accel_cal_z) * b.accel_cal_z;
    m2 = longint'(b.mag_cal_x) * b.mag_cal_x + longint'(b.mag_cal_y) * b.mag_cal_y +
         longint'(b.mag_cal_z) * b.mag_cal_z;
    lim2 = longint'(mag_limit) * mag_limit;
    if (a2 != 0) begin
      bin_idx = direction_cell(b.accel_cal_x, b.accel_cal_y, b.accel_cal_z);
      r.accel_cell = bin_idx[10:0];
      if (a2 <= lim2 && !accel_occ[bin_idx]) begin
        accel_occ[bin_idx] = 1'b1;
        accel_fill_cnt++;
        r.accel_stored = 1'b1;
      end
    end
    if (m2 != 0) begin
      bin_idx = direction_cell(b.mag_cal_x, b.mag_cal_y, b.mag_cal_z);
      r.mag_cell = bin_idx[10:0];
      if (!mag_occ[bin_idx]) begin
        mag_occ[bin_idx] = 1'b1;
        mag_fill_cnt++;
        r.mag_stored = 1'b1;
      end
    end
    r.accel_filled = accel_fill_cnt;
    r.mag_filled = mag_fill_cnt;
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // Sender: offers readings from the queue and predicts each accepted beat.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) expected_bins.push_back(bin_reading(in_if.data));
      if (!in_if.valid || in_if.ready) begin
        if (send_gap > 0 || pending_readings.size() == 0) begin
          if (send_gap > 0) send_gap <= send_gap - 1;
          in_if.valid <= 1'b0;
        end else begin
          in_if.data <= pending_readings.pop_front();
          in_if.valid <= 1'b1;
          send_gap <= pick_gap();
        end
      end
    end else begin
      in_if.valid <= 1'b0;
      in_if.data <= '0;
    end
  end

  // Receiver: random stalls plus the long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (hold_off) begin
        out_if.ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        recv_gap <= pick_gap();
      end
    end else begin
      out_if.ready <= 1'b0;
    end
  end

  // Result checker.
  always @(posedge clk_i) begin
    out_beat_t want, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (expected_bins.size() == 0) begin
        $display("unexpected result beat at cycle %0d", cycle_count);
        fail_count++;
      end else begin
        want = expected_bins.pop_front();
        if (got.accel_cell !== want.accel_cell)
          report_mismatch("accel_cell", got.accel_cell, want.accel_cell);
        if (got.accel_stored !== want.accel_stored)
          report_mismatch("accel_stored", got.accel_stored, want.accel_stored);
        if (got.mag_cell !== want.mag_cell)
          report_mismatch("mag_cell", got.mag_cell, want.mag_cell);
        if (got.mag_stored !== want.mag_stored)
          report_mismatch("mag_stored", got.mag_stored, want.mag_stored);
        if (got.accel_filled !== want.accel_filled)
          report_mismatch("accel_filled", got.accel_filled, want.accel_filled);
        if (got.mag_filled !== want.mag_filled)
          report_mismatch("mag_filled", got.mag_filled, want.mag_filled);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL sphere_coverage_binner");
      $finish;
    end
  end

  // Long receiver hold-off so that the block backs up onto its input.
  initial begin
    wait (long_hold_req);
    hold_off = 1'b1;
    repeat (1500) @(posedge clk_i);
    hold_off = 1'b0;
  end

  function automatic logic signed [15:0] rand_comp(int kind);
    case (kind)
      0: return 16'($urandom_range(0, 10000)) - 16'sd5000;
      1: return 16'($urandom);
      default: return ($urandom_range(0, 2) == 0) ? 16'sd0 : 16'($urandom_range(0, 8000)) - 16'sd4000;
    endcase
  endfunction

  function automatic in_beat_t rand_reading();
    in_beat_t b;
    int r, ka, km;
    b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    r = $urandom_range(0, 99);
    ka = (r < 55) ? 0 : (r < 80) ? 1 : 2;
    r = $urandom_range(0, 99);
    km = (r < 55) ? 0 : (r < 80) ? 1 : 2;
    b.accel_cal_x = rand_comp(ka); b.accel_cal_y = rand_comp(ka); b.accel_cal_z = rand_comp(ka);
    b.mag_cal_x = rand_comp(km); b.mag_cal_y = rand_comp(km); b.mag_cal_z = rand_comp(km);
    if ($urandom_range(0, 19) == 0) {b.accel_cal_x, b.accel_cal_y, b.accel_cal_z} = '0;
    if ($urandom_range(0, 19) == 0) {b.mag_cal_x, b.mag_cal_y, b.mag_cal_z} = '0;
    return b;
  endfunction

  function automatic in_beat_t pair(logic signed [15:0] ax, logic signed [15:0] ay,
                                    logic signed [15:0] az, logic signed [15:0] mx,
                                    logic signed [15:0] my, logic signed [15:0] mz);
    in_beat_t b;
    b = in_beat_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    {b.accel_cal_x, b.accel_cal_y, b.accel_cal_z} = {ax, ay, az};
    {b.mag_cal_x, b.mag_cal_y, b.mag_cal_z} = {mx, my, mz};
    return b;
  endfunction

  task automatic drain_block();
    do @(posedge clk_i);
    while (pending_readings.size() != 0 || in_if.valid || expected_bins.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [14:0] v);
    cfg_wdata_i <= v;
    cfg_we_i <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    mag_limit = v;
    @(posedge clk_i);
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) pending_readings.push_back(rand_reading());
  endtask

  // Stimulus: directed corner readings, then random phases at several limits.
  initial begin
    accel_fill_cnt = '0;
    mag_fill_cnt = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Zero vectors, poles, the +pi seam, extremes, repeats and over-limit readings.
    pending_readings.push_back(pair(0, 0, 0, 0, 0, 0));
    pending_readings.push_back(pair(0, 0, 4096, 0, 0, 4096));
    pending_readings.push_back(pair(0, 0, -4096, 0, 0, -4096));
    pending_readings.push_back(pair(-4096, 0, 0, -4096, 0, 0));
    pending_readings.push_back(pair(-4096, 0, 0, -4096, 0, 0));
    pending_readings.push_back(pair(4096, 0, 0, 4096, -1, 0));
    pending_readings.push_back(pair(0, 4096, 0, 0, -4096, 0));
    pending_readings.push_back(pair(4506, 0, 0, 32767, 32767, 32767));
    pending_readings.push_back(pair(0, 4507, 0, -32768, -32768, -32768));
    pending_readings.push_back(pair(-32768, -32768, -32768, 32767, -32768, 0));
    pending_readings.push_back(pair(32767, 32767, 32767, -32768, 0, 1));
    pending_readings.push_back(pair(1, 0, 0, 0, 0, 1));
    pending_readings.push_back(pair(-1, -1, -1, 1, 1, -1));
    pending_readings.push_back(pair(2000, 2000, 2000, 0, 0, 0));
    pending_readings.push_back(pair(0, 0, 0, 100, -100, 50));
    pending_readings.push_back(pair(-2600, -2600, 2600, -1, 0, 0));
    pending_readings.push_back(pair(0, -1, 0, 0, 1, 0));
    pending_readings.push_back(pair(-1, 0, 0, -1, 0, 0));
    pending_readings.push_back(pair(3000, -3000, 0, -3000, 3000, 0));
    drain_block();

    calm = 1'b1;
    queue_random(150);
    drain_block();
    calm = 1'b0;
    queue_random(300);
    drain_block();

    write_limit(15'd0);
    queue_random(300);
    drain_block();

    write_limit(15'h7FFF);
    long_hold_req = 1'b1;
    queue_random(450);
    drain_block();

    write_limit(15'($urandom_range(1000, 12000)));
    queue_random(300);
    drain_block();

    write_limit(LimitReset);
    queue_random(500);
    drain_block();

    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS sphere_coverage_binner");
    end else begin
      $display("FAIL sphere_coverage_binner");
    end
    $finish;
  end

endmodule
